// ===== src/clws_pkg.sv =====
`default_nettype none

package clws_pkg;

  localparam int COLUMNS = 20;
  localparam int ROWS = 4;
  localparam int CELLS = ROWS * COLUMNS;
  localparam int CURSOR_W = $clog2(CELLS + 1);
  localparam int ROW_W = 2;
  localparam int COL_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int MAX_BYTES = 3;
  localparam int BYTE_IDX_W = 2;
  localparam int XFER_IDX_W = 3;

  typedef enum logic [1:0] {
    FUNC_CHAR  = 2'd0,
    FUNC_CMD   = 2'd1,
    FUNC_GOTO  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOUR_BIT = 3'd0,
    CFG_ROW0_CMD = 3'd1,
    CFG_ROW1_CMD = 3'd2,
    CFG_ROW2_CMD = 3'd3,
    CFG_ROW3_CMD = 3'd4,
    CFG_CLEAR_CMD = 3'd5
  } cfg_idx_e;

  localparam logic [7:0] ROW0_CMD_RST = 8'h80;
  localparam logic [7:0] ROW1_CMD_RST = 8'hC0;
  localparam logic [7:0] ROW2_CMD_RST = 8'h94;
  localparam logic [7:0] ROW3_CMD_RST = 8'hD4;
  localparam logic [7:0] CLEAR_CMD_RST = 8'h01;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       payload;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_value;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/char_lcd_write_sequencer_top.sv =====
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+--------------------------
// in       | input     | in_valid_i / in_stall_o  | in_item_i  (func, payload, row, column)
// out      | output    | out_valid_o / out_stall_i| out_item_o (reg_select, bus_value, last)
// cfg      | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// an item is decoded into up to three bytes in the cycle it is accepted; the
// job register then sends one transfer per cycle while out is not stalled:
// one per byte, or two per byte in four-bit mode.
// a new item is taken in the cycle the previous item's last transfer leaves.
// items that send nothing leave the block idle. reset clears the cursor, the job
// and loads the default command bytes. a stall on out holds the transfer.
`default_nettype none

module char_lcd_write_sequencer_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  clws_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output clws_pkg::out_item_t            out_item_o,
  input  wire                            cfg_we_i,
  input  wire [clws_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [clws_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration
  logic       four_bit_q;
  logic [7:0] row_cmd_q [4];
  logic [7:0] clear_cmd_q;

  // cursor and job
  logic [clws_pkg::CURSOR_W-1:0]   cursor_q, cursor_d;
  logic                            busy_q, busy_d;
  logic [7:0]                      job_byte_q [clws_pkg::MAX_BYTES];
  logic [7:0]                      job_byte_d [clws_pkg::MAX_BYTES];
  logic [clws_pkg::MAX_BYTES-1:0]  job_rs_q, job_rs_d;
  logic [1:0]                      job_cnt_q, job_cnt_d;
  logic                            job_nib_q;
  logic [clws_pkg::XFER_IDX_W-1:0] idx_q, idx_d;

  logic                            in_fire, out_fire, done;
  logic [clws_pkg::XFER_IDX_W-1:0] total;
  logic [clws_pkg::BYTE_IDX_W-1:0] bsel;
  logic [7:0]                      cur_byte;
  logic                            cur_rs;
  logic                            row_hit;
  logic [1:0]                      hit_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q   <= 1'b1;
      row_cmd_q[0] <= clws_pkg::ROW0_CMD_RST;
      row_cmd_q[1] <= clws_pkg::ROW1_CMD_RST;
      row_cmd_q[2] <= clws_pkg::ROW2_CMD_RST;
      row_cmd_q[3] <= clws_pkg::ROW3_CMD_RST;
      clear_cmd_q  <= clws_pkg::CLEAR_CMD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clws_pkg::CFG_FOUR_BIT:  four_bit_q   <= cfg_wdata_i[0];
        clws_pkg::CFG_ROW0_CMD:  row_cmd_q[0] <= cfg_wdata_i;
        clws_pkg::CFG_ROW1_CMD:  row_cmd_q[1] <= cfg_wdata_i;
        clws_pkg::CFG_ROW2_CMD:  row_cmd_q[2] <= cfg_wdata_i;
        clws_pkg::CFG_ROW3_CMD:  row_cmd_q[3] <= cfg_wdata_i;
        clws_pkg::CFG_CLEAR_CMD: clear_cmd_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // output side
  assign total = job_nib_q ? {job_cnt_q, 1'b0} : {1'b0, job_cnt_q};
  assign bsel  = job_nib_q ? idx_q[2:1] : idx_q[1:0];

  always_comb begin
    unique case (bsel)
      2'd0:    begin cur_byte = job_byte_q[0]; cur_rs = job_rs_q[0]; end
      2'd1:    begin cur_byte = job_byte_q[1]; cur_rs = job_rs_q[1]; end
      default: begin cur_byte = job_byte_q[2]; cur_rs = job_rs_q[2]; end
    endcase
  end

  always_comb begin
    out_valid_o = busy_q;
    out_item_o.reg_select = cur_rs;
    if (job_nib_q) begin
      out_item_o.bus_value = idx_q[0] ? {4'd0, cur_byte[3:0]} : {4'd0, cur_byte[7:4]};
    end else begin
      out_item_o.bus_value = cur_byte;
    end
    out_item_o.last = (idx_q == total - 3'd1);
  end

  assign out_fire   = out_valid_o && !out_stall_i;
  assign done       = out_fire && out_item_o.last;
  assign in_stall_o = busy_q && !done;
  assign in_fire    = in_valid_i && !in_stall_o;

  // cursor at the start of a row other than the first
  always_comb begin
    row_hit = 1'b0;
    hit_row = 2'd0;
    for (int k = 1; k < clws_pkg::ROWS; k++) begin
      if (cursor_q == clws_pkg::CURSOR_W'(k * clws_pkg::COLUMNS)) begin
        row_hit = 1'b1;
        hit_row = 2'(k);
      end
    end
  end

  // decode the item into a list of bytes
  always_comb begin
    cursor_d = cursor_q;
    job_cnt_d = 2'd0;
    job_rs_d = '0;
    for (int i = 0; i < clws_pkg::MAX_BYTES; i++) begin
      job_byte_d[i] = 8'd0;
    end
    unique case (in_item_i.func)
      clws_pkg::FUNC_CHAR: begin
        if (cursor_q == clws_pkg::CURSOR_W'(clws_pkg::CELLS)) begin
          job_byte_d[0] = clear_cmd_q;
          job_byte_d[1] = row_cmd_q[0];
          job_byte_d[2] = in_item_i.payload;
          job_rs_d = 3'b100;
          job_cnt_d = 2'd3;
          cursor_d = clws_pkg::CURSOR_W'(1);
        end else if (row_hit) begin
          job_byte_d[0] = row_cmd_q[hit_row];
          job_byte_d[1] = in_item_i.payload;
          job_rs_d = 3'b010;
          job_cnt_d = 2'd2;
          cursor_d = cursor_q + clws_pkg::CURSOR_W'(1);
        end else begin
          job_byte_d[0] = in_item_i.payload;
          job_rs_d = 3'b001;
          job_cnt_d = 2'd1;
          cursor_d = cursor_q + clws_pkg::CURSOR_W'(1);
        end
      end
      clws_pkg::FUNC_CMD: begin
        job_byte_d[0] = in_item_i.payload;
        job_cnt_d = 2'd1;
      end
      clws_pkg::FUNC_GOTO: begin
        if ((32'(in_item_i.column) < clws_pkg::COLUMNS) &&
            (32'(in_item_i.row) < clws_pkg::ROWS)) begin
          job_byte_d[0] = row_cmd_q[in_item_i.row] + {3'd0, in_item_i.column};
          job_cnt_d = 2'd1;
          cursor_d = clws_pkg::CURSOR_W'(32'(in_item_i.row) * clws_pkg::COLUMNS
                                         + 32'(in_item_i.column));
        end
      end
      default: begin
        job_byte_d[0] = clear_cmd_q;
        job_cnt_d = 2'd1;
        cursor_d = '0;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d = idx_q;
    if (in_fire) begin
      busy_d = (job_cnt_d != 2'd0);
      idx_d = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (out_fire) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      busy_q <= 1'b0;
      idx_q <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q <= idx_d;
      if (in_fire) begin
        cursor_q <= cursor_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_byte_q <= job_byte_d;
      job_rs_q <= job_rs_d;
      job_cnt_q <= job_cnt_d;
      job_nib_q <= four_bit_q;
    end
  end

  cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= clws_pkg::CURSOR_W'(clws_pkg::CELLS))
    else $error("cursor beyond screen");

  idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < total))
    else $error("transfer index past job length");

  cmd_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_item_i.func == clws_pkg::FUNC_CMD) |=> out_valid_o)
    else $error("raw command produced no transfer");

  idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !in_fire |=> !out_valid_o)
    else $error("transfer after last of item");

endmodule

`default_nettype wire

// ===== tb/char_lcd_write_sequencer_top_test.sv =====
`default_nettype none

module char_lcd_write_sequencer_top_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 30;
  localparam int NUM_PHASES = 7;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  clws_pkg::in_item_t              in_item_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  clws_pkg::out_item_t             out_item_o;
  logic                            cfg_we_i;
  logic [clws_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [clws_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  // mirror of the block's registers and cursor
  logic                            model_nibble_mode;
  logic [7:0]                      model_row_cmd [4];
  logic [7:0]                      model_clear_cmd;
  logic [clws_pkg::CURSOR_W-1:0]   model_cursor;

  clws_pkg::in_item_t              pending_requests [$];
  clws_pkg::out_item_t             expected_xfers [$];
  int                              queued_count;
  int                              accepted_count;
  int                              cycle_count;
  int                              fail_count;
  int                              send_idle_pct;
  int                              recv_idle_pct;
  logic                            in_took;

  char_lcd_write_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what);
    fail_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // works out the bus transfers one request causes and advances the cursor
  task automatic predict_transfers(clws_pkg::in_item_t it);
    logic [8:0]          plan [$];
    logic [7:0]          addr;
    clws_pkg::out_item_t x;
    int                  c;
    int                  total;
    int                  k;
    c = int'(model_cursor);
    case (clws_pkg::func_e'(it.func))
      clws_pkg::FUNC_CHAR: begin
        if (c == clws_pkg::CELLS) begin
          // screen full: clear, back to row 0
          plan.push_back({1'b0, model_clear_cmd});
          plan.push_back({1'b0, model_row_cmd[0]});
          model_cursor = clws_pkg::CURSOR_W'(1);
        end else begin
          if (c != 0 && c % clws_pkg::COLUMNS == 0)
            plan.push_back({1'b0, model_row_cmd[c / clws_pkg::COLUMNS]});
          model_cursor = clws_pkg::CURSOR_W'(c + 1);
        end
        plan.push_back({1'b1, it.payload});
      end
      clws_pkg::FUNC_CMD: begin
        plan.push_back({1'b0, it.payload});
      end
      clws_pkg::FUNC_GOTO: begin
        if (int'(it.column) < clws_pkg::COLUMNS && int'(it.row) < clws_pkg::ROWS) begin
          addr = model_row_cmd[it.row] + 8'(it.column);
          plan.push_back({1'b0, addr});
          model_cursor = clws_pkg::CURSOR_W'(int'(it.row) * clws_pkg::COLUMNS
                                             + int'(it.column));
        end
      end
      default: begin
        plan.push_back({1'b0, model_clear_cmd});
        model_cursor = '0;
      end
    endcase
    total = model_nibble_mode ? 2 * plan.size() : plan.size();
    k = 0;
    foreach (plan[i]) begin
      if (model_nibble_mode) begin
        k++;
        x = {plan[i][8], 4'h0, plan[i][7:4], k == total};
        expected_xfers.push_back(x);
        k++;
        x = {plan[i][8], 4'h0, plan[i][3:0], k == total};
        expected_xfers.push_back(x);
      end else begin
        k++;
        x = {plan[i][8], plan[i][7:0], k == total};
        expected_xfers.push_back(x);
      end
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    clws_pkg::out_item_t want;
    cycle_count++;
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) begin
      accepted_count++;
      predict_transfers(in_item_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_xfers.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer rs=%0b bus=%02h last=%0b",
                                  out_item_o.reg_select, out_item_o.bus_value,
                                  out_item_o.last));
      end else begin
        want = expected_xfers.pop_front();
        if (out_item_o.reg_select !== want.reg_select)
          report_mismatch($sformatf("reg_select %0b, want %0b",
                                    out_item_o.reg_select, want.reg_select));
        if (out_item_o.bus_value !== want.bus_value)
          report_mismatch($sformatf("bus_value %02h, want %02h",
                                    out_item_o.bus_value, want.bus_value));
        if (out_item_o.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_item_o.last, want.last));
      end
    end
  end

  // request driver: holds an item until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_took)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_i  <= pending_requests.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic queue_req(clws_pkg::in_item_t it);
    pending_requests.push_back(it);
    queued_count++;
  endtask

  task automatic queue_fields(clws_pkg::func_e f, logic [7:0] pay, logic [1:0] r,
                              logic [4:0] col);
    clws_pkg::in_item_t it;
    it.func    = f;
    it.payload = pay;
    it.row     = r;
    it.column  = col;
    queue_req(it);
  endtask

  // mostly characters and go-tos near row ends so the wraps are reached often
  task automatic queue_random_req();
    clws_pkg::in_item_t it;
    int                 pick;
    it.payload = 8'($urandom);
    it.row     = 2'($urandom);
    it.column  = 5'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) begin
      it.func = clws_pkg::FUNC_CHAR;
    end else if (pick < 65) begin
      it.func   = clws_pkg::FUNC_GOTO;
      it.column = 5'($urandom_range(clws_pkg::COLUMNS - 1, clws_pkg::COLUMNS - 4));
    end else if (pick < 75) begin
      it.func = clws_pkg::FUNC_GOTO;
    end else if (pick < 90) begin
      it.func = clws_pkg::FUNC_CMD;
    end else begin
      it.func = clws_pkg::FUNC_CLEAR;
    end
    queue_req(it);
  endtask

  task automatic write_reg(clws_pkg::cfg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    case (idx)
      clws_pkg::CFG_FOUR_BIT:  model_nibble_mode = value[0];
      clws_pkg::CFG_ROW0_CMD:  model_row_cmd[0] = value;
      clws_pkg::CFG_ROW1_CMD:  model_row_cmd[1] = value;
      clws_pkg::CFG_ROW2_CMD:  model_row_cmd[2] = value;
      clws_pkg::CFG_ROW3_CMD:  model_row_cmd[3] = value;
      clws_pkg::CFG_CLEAR_CMD: model_clear_cmd = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic settle_block();
    do @(negedge clk_i);
    while (accepted_count != queued_count || expected_xfers.size() != 0);
    // items that send nothing may still be in the block
    repeat (8) @(negedge clk_i);
  endtask

  task automatic queue_directed();
    queue_fields(clws_pkg::FUNC_CLEAR, 8'h00, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h00, 2'd3, 5'd31);
    queue_fields(clws_pkg::FUNC_CHAR,  8'hFF, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_CHAR,  8'hA5, 2'd1, 5'd10);
    queue_fields(clws_pkg::FUNC_CMD,   8'h00, 2'd2, 5'd21);
    queue_fields(clws_pkg::FUNC_CMD,   8'hFF, 2'd3, 5'd31);
    queue_fields(clws_pkg::FUNC_GOTO,  8'hFF, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_GOTO,  8'h00, 2'd3, 5'd19);
    // column out of range
    queue_fields(clws_pkg::FUNC_GOTO,  8'h00, 2'd1, 5'd20);
    queue_fields(clws_pkg::FUNC_GOTO,  8'h5A, 2'd2, 5'd31);
    // end of row 0, then row 1 and row 2
    queue_fields(clws_pkg::FUNC_GOTO,  8'h00, 2'd0, 5'd19);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h41, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h42, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_GOTO,  8'h00, 2'd1, 5'd19);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h43, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h44, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_GOTO,  8'h00, 2'd2, 5'd19);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h45, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h46, 2'd0, 5'd0);
    // end of screen wraps to the top
    queue_fields(clws_pkg::FUNC_GOTO,  8'h00, 2'd3, 5'd19);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h47, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h48, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h49, 2'd0, 5'd0);
    queue_fields(clws_pkg::FUNC_CLEAR, 8'hFF, 2'd3, 5'd31);
    queue_fields(clws_pkg::FUNC_CHAR,  8'h7E, 2'd2, 5'd5);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_stall_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_took        = 1'b0;
    queued_count   = 0;
    accepted_count = 0;
    cycle_count    = 0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    model_nibble_mode = 1'b1;
    model_row_cmd[0]  = clws_pkg::ROW0_CMD_RST;
    model_row_cmd[1]  = clws_pkg::ROW1_CMD_RST;
    model_row_cmd[2]  = clws_pkg::ROW2_CMD_RST;
    model_row_cmd[3]  = clws_pkg::ROW3_CMD_RST;
    model_clear_cmd   = clws_pkg::CLEAR_CMD_RST;
    model_cursor      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase <= 2) begin
        send_idle_pct = 25;
        recv_idle_pct = 47;
      end else if (phase <= 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 0) begin
        queue_directed();
      end else begin
        case (phase)
          1: begin
            write_reg(clws_pkg::CFG_FOUR_BIT, 8'd0);
            for (int r = 0; r < 4; r++)
              write_reg(clws_pkg::cfg_idx_e'(clws_pkg::CFG_ROW0_CMD + r), 8'h00);
            write_reg(clws_pkg::CFG_CLEAR_CMD, 8'h00);
          end
          2: begin
            write_reg(clws_pkg::CFG_FOUR_BIT, 8'd1);
            for (int r = 0; r < 4; r++)
              write_reg(clws_pkg::cfg_idx_e'(clws_pkg::CFG_ROW0_CMD + r), 8'hFF);
            write_reg(clws_pkg::CFG_CLEAR_CMD, 8'hFF);
          end
          default: begin
            write_reg(clws_pkg::CFG_FOUR_BIT, (phase == 4 || phase == 5) ? 8'd1 : 8'd0);
            for (int r = 0; r < 4; r++)
              write_reg(clws_pkg::cfg_idx_e'(clws_pkg::CFG_ROW0_CMD + r), 8'($urandom));
            write_reg(clws_pkg::CFG_CLEAR_CMD, 8'($urandom));
          end
        endcase
        repeat (RANDOM_PER_PHASE) queue_random_req();
      end
      settle_block();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
